### hw/rtl/bls_pkg.sv
package bls_pkg;

    localparam int MAX_BANDS_DEF   = 128;
    localparam int LEVEL_BITS_DEF  = 16;
    localparam int HOLD_FRAMES_DEF = 10;

    localparam int BAND_W   = 7;
    localparam int WEIGHT_W = 9;
    localparam int DECAY_W  = 16;
    localparam int COUNT_W  = 8;
    localparam int HOLD_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 9'd77;
    localparam logic [DECAY_W-1:0]  DECAY_RESET   = 16'd1311;
    localparam logic [COUNT_W-1:0]  COUNT_RESET   = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH_WEIGHT = 2'd0,
        CFG_DECAY_STEP    = 2'd1,
        CFG_BAND_COUNT    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] smooth_weight;
        logic [DECAY_W-1:0]  decay_step;
        logic [COUNT_W-1:0]  band_count;
    } cfg_t;

endpackage

### hw/rtl/bls_if.sv
interface bls_in_if #(
    parameter int LEVEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [6:0]            band;
    logic [LEVEL_BITS-1:0] level;

    modport source (output valid, output band, output level, input ready);
    modport sink   (input valid, input band, input level, output ready);
endinterface

interface bls_out_if #(
    parameter int LEVEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [6:0]            band_out;
    logic [LEVEL_BITS-1:0] smoothed_level;
    logic [LEVEL_BITS-1:0] peak_level;
    logic                  peak_holding;
    logic                  band_error;

    modport source (output valid, output band_out, output smoothed_level,
                    output peak_level, output peak_holding, output band_error,
                    input ready);
    modport sink   (input valid, input band_out, input smoothed_level,
                    input peak_level, input peak_holding, input band_error,
                    output ready);
endinterface

### hw/rtl/band_level_smooth_peak_hold_top.sv
// Path: an accepted beat is registered in stage 1 (band, level and the RAM read), then its
// result loads the output register, from which it is offered; an output stall holds stage 1.
// Throughput: one beat per cycle unless out_ch stalls; the per-band store is a one-read, one-write
// port RAM, its read registered; a write to the same band in the preceding cycle is forwarded.
// Reset: rst_n clears the pipeline and output valid flags, all band valid marks and
// loads the register defaults; the band RAM itself is not cleared.
module band_level_smooth_peak_hold_top
    import bls_pkg::*;
#(
    parameter int MAX_BANDS   = MAX_BANDS_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF,
    parameter int HOLD_FRAMES = HOLD_FRAMES_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bls_in_if.sink                in_ch,
    bls_out_if.source             out_ch
);

    localparam int ADDR_W = $clog2((MAX_BANDS > 1) ? MAX_BANDS : 2);
    localparam int MEM_W  = HOLD_W + 2 * LEVEL_BITS;

    cfg_t cfg_reg;

    logic [MEM_W-1:0] mem [MAX_BANDS];
    logic [MAX_BANDS-1:0] valid_reg;

    logic                  s1_valid_reg;
    logic [BAND_W-1:0]     s1_band_reg;
    logic [LEVEL_BITS-1:0] s1_level_reg;
    logic [MEM_W-1:0]      rd_reg;
    logic                  fwd_hit_reg;
    logic [MEM_W-1:0]      fwd_data_reg;

    logic                  out_valid_reg;
    logic [BAND_W-1:0]     out_band_reg;
    logic [LEVEL_BITS-1:0] out_smooth_reg;
    logic [LEVEL_BITS-1:0] out_peak_reg;
    logic                  out_hold_reg;
    logic                  out_err_reg;

    logic                  s1_adv;
    logic                  in_acc;
    logic [ADDR_W-1:0]     in_addr;
    logic [ADDR_W-1:0]     s1_addr;
    logic [MEM_W-1:0]      s1_state;
    logic                  s1_in_range;
    logic                  s1_wr;
    logic [LEVEL_BITS-1:0] new_smooth;
    logic [LEVEL_BITS-1:0] new_peak;
    logic [HOLD_W-1:0]     new_hold;
    logic [MEM_W-1:0]      wr_data;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign in_addr     = ADDR_W'(in_ch.band);
    assign s1_addr     = ADDR_W'(s1_band_reg);
    assign s1_state    = fwd_hit_reg ? fwd_data_reg : rd_reg;
    assign s1_wr       = s1_adv && s1_in_range;
    assign wr_data     = {new_hold, new_peak, new_smooth};

    bls_update #(
        .MAX_BANDS   (MAX_BANDS),
        .LEVEL_BITS  (LEVEL_BITS),
        .HOLD_FRAMES (HOLD_FRAMES)
    ) u_update (
        .cfg        (cfg_reg),
        .band       (s1_band_reg),
        .level      (s1_level_reg),
        .valid_mark (valid_reg[s1_addr]),
        .old_smooth (s1_state[LEVEL_BITS-1:0]),
        .old_peak   (s1_state[2*LEVEL_BITS-1:LEVEL_BITS]),
        .old_hold   (s1_state[MEM_W-1:2*LEVEL_BITS]),
        .in_range   (s1_in_range),
        .new_smooth (new_smooth),
        .new_peak   (new_peak),
        .new_hold   (new_hold)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smooth_weight <= WEIGHT_RESET;
            cfg_reg.decay_step    <= DECAY_RESET;
            cfg_reg.band_count    <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SMOOTH_WEIGHT: cfg_reg.smooth_weight <= cfg_data[WEIGHT_W-1:0];
                CFG_DECAY_STEP:    cfg_reg.decay_step    <= cfg_data[DECAY_W-1:0];
                CFG_BAND_COUNT:    cfg_reg.band_count    <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // a band count write drops every valid mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cfg_we && (cfg_index == CFG_BAND_COUNT))
        begin
            valid_reg <= '0;
        end
        else if (s1_wr)
        begin
            valid_reg[s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_wr)
        begin
            mem[s1_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    // catch the write landing on the same band as the beat being read
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_band_reg  <= in_ch.band;
            s1_level_reg <= in_ch.level;
            fwd_hit_reg  <= s1_wr && (s1_band_reg == in_ch.band);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_band_reg   <= s1_band_reg;
            out_err_reg    <= !s1_in_range;
            out_smooth_reg <= s1_in_range ? new_smooth : '0;
            out_peak_reg   <= s1_in_range ? new_peak   : '0;
            out_hold_reg   <= s1_in_range && (new_hold != '0);
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.band_out       = out_band_reg;
    assign out_ch.smoothed_level = out_smooth_reg;
    assign out_ch.peak_level     = out_peak_reg;
    assign out_ch.peak_holding   = out_hold_reg;
    assign out_ch.band_error     = out_err_reg;

endmodule

### hw/rtl/bls_update.sv
module bls_update
    import bls_pkg::*;
#(
    parameter int MAX_BANDS   = MAX_BANDS_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF,
    parameter int HOLD_FRAMES = HOLD_FRAMES_DEF
)(
    input  cfg_t                  cfg,
    input  logic [BAND_W-1:0]     band,
    input  logic [LEVEL_BITS-1:0] level,
    input  logic                  valid_mark,
    input  logic [LEVEL_BITS-1:0] old_smooth,
    input  logic [LEVEL_BITS-1:0] old_peak,
    input  logic [HOLD_W-1:0]     old_hold,
    output logic                  in_range,
    output logic [LEVEL_BITS-1:0] new_smooth,
    output logic [LEVEL_BITS-1:0] new_peak,
    output logic [HOLD_W-1:0]     new_hold
);

    localparam int CMP_W = 11;
    localparam logic [CMP_W-1:0] MAX_BANDS_C = CMP_W'(MAX_BANDS);
    localparam int DW = (LEVEL_BITS > DECAY_W) ? LEVEL_BITS : DECAY_W;
    localparam int PW = LEVEL_BITS + WEIGHT_W + 1;
    localparam logic [HOLD_W-1:0] HOLD_INIT = HOLD_W'(HOLD_FRAMES);

    logic [WEIGHT_W-1:0]   w;
    logic [LEVEL_BITS-1:0] base_smooth;
    logic [LEVEL_BITS-1:0] base_peak;
    logic [HOLD_W-1:0]     base_hold;
    logic [PW-1:0]         mix;
    logic [DW-1:0]         peak_ext;
    logic [DW-1:0]         decay_ext;
    logic [DW-1:0]         dropped;

    assign in_range = (CMP_W'(band) < CMP_W'(cfg.band_count)) && (CMP_W'(band) < MAX_BANDS_C);

    assign w = (cfg.smooth_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smooth_weight;

    // first beat for a band seeds its smooth and peak with the level and its hold with zero
    assign base_smooth = valid_mark ? old_smooth : level;
    assign base_peak   = valid_mark ? old_peak   : level;
    assign base_hold   = valid_mark ? old_hold   : '0;

    assign mix = PW'(base_smooth) * PW'(w) + PW'(level) * PW'(WEIGHT_ONE - w);
    assign new_smooth = mix[LEVEL_BITS+7:8];

    assign peak_ext  = DW'(base_peak);
    assign decay_ext = DW'(cfg.decay_step);
    assign dropped   = (peak_ext > decay_ext) ? (peak_ext - decay_ext) : '0;

    always_comb
    begin
        new_peak = base_peak;
        new_hold = base_hold;
        if (level >= base_peak)
        begin
            new_peak = level;
            new_hold = HOLD_INIT;
        end
        else if (base_hold != '0)
        begin
            new_hold = base_hold - HOLD_W'(1);
        end
        else if (dropped < DW'(level))
        begin
            new_peak = level;
        end
        else
        begin
            new_peak = LEVEL_BITS'(dropped);
        end
    end

endmodule

### tb/band_level_smooth_peak_hold_top_test.sv
`timescale 1ns / 1ps

module band_level_smooth_peak_hold_top_test;
    import bls_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 160;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [BAND_W-1:0]         band_out;
        logic [LEVEL_BITS_DEF-1:0] smoothed;
        logic [LEVEL_BITS_DEF-1:0] peak;
        logic                      holding;
        logic                      band_err;
    } meter_result_t;

    typedef enum logic {ROW_LEVEL, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      reg_idx;
        logic [BAND_W-1:0]         band;
        logic [CFG_DATA_W-1:0]     value;
        int                        reps;
        bit                        known;
        meter_result_t             want;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bls_in_if  #(.LEVEL_BITS(LEVEL_BITS_DEF)) in_ch ();
    bls_out_if #(.LEVEL_BITS(LEVEL_BITS_DEF)) out_ch ();

    band_level_smooth_peak_hold_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor copy of registers and per-band state
    logic [WEIGHT_W-1:0]       weight_q;
    logic [DECAY_W-1:0]        decay_q;
    logic [COUNT_W-1:0]        count_q;
    logic [LEVEL_BITS_DEF-1:0] smooth_mem [MAX_BANDS_DEF];
    logic [LEVEL_BITS_DEF-1:0] peak_mem   [MAX_BANDS_DEF];
    logic [HOLD_W-1:0]         hold_mem   [MAX_BANDS_DEF];
    bit                        seen       [MAX_BANDS_DEF];

    meter_result_t expected_meters [$];
    script_row_t   script [$];

    bit calm;
    int mismatches;
    int beats_sent;
    int results_checked;
    int errors_seen;
    int holds_seen;
    int reg_writes;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic meter_result_t meter_update(input logic [BAND_W-1:0] band,
                                                   input logic [LEVEL_BITS_DEF-1:0] level);
        meter_result_t r;
        int unsigned   span;
        int unsigned   w;
        int unsigned   old_s;
        int unsigned   pk;
        int unsigned   mix;
        logic [HOLD_W-1:0] hold;
        span = (count_q > MAX_BANDS_DEF) ? MAX_BANDS_DEF : count_q;
        w = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
        r = '0;
        r.band_out = band;
        if (band >= span) begin
            r.band_err = 1'b1;
            return r;
        end
        if (!seen[band]) begin
            old_s = level;
            pk = level;
            hold = '0;
            seen[band] = 1'b1;
        end else begin
            old_s = smooth_mem[band];
            pk = peak_mem[band];
            hold = hold_mem[band];
        end
        mix = (old_s * w + level * (WEIGHT_ONE - w)) >> 8;
        if (level >= pk) begin
            pk = level;
            hold = HOLD_W'(HOLD_FRAMES_DEF);
        end else if (hold != 0) begin
            hold = hold - 1'b1;
        end else begin
            pk = (pk > decay_q) ? pk - decay_q : 0;
            if (pk < level)
                pk = level;
        end
        smooth_mem[band] = mix[LEVEL_BITS_DEF-1:0];
        peak_mem[band] = pk[LEVEL_BITS_DEF-1:0];
        hold_mem[band] = hold;
        r.smoothed = mix[LEVEL_BITS_DEF-1:0];
        r.peak = pk[LEVEL_BITS_DEF-1:0];
        r.holding = (hold != 0);
        return r;
    endfunction

    function automatic logic [BAND_W-1:0] pick_band();
        int unsigned span;
        span = (count_q > MAX_BANDS_DEF) ? MAX_BANDS_DEF : count_q;
        if (span == 0)
            return BAND_W'($urandom);
        // favor a few bands so hold and decay get long runs
        if (span > 4 && $urandom_range(0, 1) == 0)
            return BAND_W'($urandom_range(0, 3));
        return BAND_W'($urandom_range(0, span - 1));
    endfunction

    function automatic script_row_t level_row(input logic [BAND_W-1:0] band,
                                              input logic [CFG_DATA_W-1:0] level,
                                              input int reps);
        script_row_t r;
        r = '{kind: ROW_LEVEL, reg_idx: '0, band: band, value: level, reps: reps,
              known: 1'b0, want: '0};
        return r;
    endfunction

    function automatic script_row_t known_row(input logic [BAND_W-1:0] band,
                                              input logic [CFG_DATA_W-1:0] level,
                                              input logic [LEVEL_BITS_DEF-1:0] smoothed,
                                              input logic [LEVEL_BITS_DEF-1:0] peak,
                                              input logic holding,
                                              input logic band_err);
        script_row_t r;
        r = level_row(band, level, 1);
        r.known = 1'b1;
        r.want = '{band_out: band, smoothed: smoothed, peak: peak,
                   holding: holding, band_err: band_err};
        return r;
    endfunction

    function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        script_row_t r;
        r = level_row('0, data, 0);
        r.kind = ROW_REG;
        r.reg_idx = idx;
        return r;
    endfunction

    task automatic push_level(input logic [BAND_W-1:0] band,
                              input logic [LEVEL_BITS_DEF-1:0] level,
                              input bit known = 1'b0,
                              input meter_result_t want = '0);
        meter_result_t predicted;
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.band  <= band;
        in_ch.level <= level;
        do @(posedge clk); while (!in_ch.ready);
        predicted = meter_update(band, level);
        expected_meters.push_back(known ? want : predicted);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_ch.valid <= 1'b0;
        // hold until every beat in flight has come out
        do @(posedge clk); while (expected_meters.size() != 0);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SMOOTH_WEIGHT: weight_q = data[WEIGHT_W-1:0];
            CFG_DECAY_STEP:    decay_q = data[DECAY_W-1:0];
            CFG_BAND_COUNT:
            begin
                count_q = data[COUNT_W-1:0];
                foreach (seen[i])
                    seen[i] = 1'b0;
            end
            default: ;
        endcase
        reg_writes++;
    endtask

    // output side: random stall bursts, none once calm
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            if (calm) begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end else begin
                out_ch.ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : result_check
        meter_result_t got;
        meter_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = '{band_out: out_ch.band_out, smoothed: out_ch.smoothed_level,
                    peak: out_ch.peak_level, holding: out_ch.peak_holding,
                    band_err: out_ch.band_error};
            if (expected_meters.size() == 0) begin
                log_mismatch($sformatf("unexpected beat for band %0d", got.band_out));
            end else begin
                want = expected_meters.pop_front();
                if (got.band_out !== want.band_out)
                    log_mismatch($sformatf("band_out got %0d want %0d",
                                           got.band_out, want.band_out));
                if (got.smoothed !== want.smoothed)
                    log_mismatch($sformatf("band %0d smoothed_level got %0d want %0d",
                                           want.band_out, got.smoothed, want.smoothed));
                if (got.peak !== want.peak)
                    log_mismatch($sformatf("band %0d peak_level got %0d want %0d",
                                           want.band_out, got.peak, want.peak));
                if (got.holding !== want.holding)
                    log_mismatch($sformatf("band %0d peak_holding got %b want %b",
                                           want.band_out, got.holding, want.holding));
                if (got.band_err !== want.band_err)
                    log_mismatch($sformatf("band %0d band_error got %b want %b",
                                           want.band_out, got.band_err, want.band_err));
                results_checked++;
                if (want.band_err)
                    errors_seen++;
                if (want.holding)
                    holds_seen++;
            end
        end
    end

    initial begin : stimulus
        int          done;
        int          run;
        logic [BAND_W-1:0] b;
        logic [LEVEL_BITS_DEF-1:0] lvl;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_SMOOTH_WEIGHT;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.band   <= '0;
        in_ch.level  <= '0;
        calm = 1'b0;
        weight_q = WEIGHT_RESET;
        decay_q = DECAY_RESET;
        count_q = COUNT_RESET;
        foreach (seen[i])
            seen[i] = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // first beat of a band loads level, lowest and highest bands, out of range
        script.push_back(known_row(0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
        script.push_back(known_row(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        // count the hold down, then decay once
        script.push_back(level_row(1, 16'd0, 11));
        // decayed peak falls below the level: floor at level
        script.push_back(level_row(1, 16'd63500, 1));
        script.push_back(known_row(15, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0));
        script.push_back(known_row(16, 16'd5, 16'd0, 16'd0, 1'b0, 1'b1));
        script.push_back(known_row(127, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b1));
        // decay larger than the peak saturates at zero
        script.push_back(reg_row(CFG_DECAY_STEP, 16'hFFFF));
        script.push_back(level_row(1, 16'd0, 1));
        script.push_back(reg_row(CFG_SMOOTH_WEIGHT, 16'd256));
        script.push_back(level_row(0, 16'hFFFF, 1));
        script.push_back(reg_row(CFG_SMOOTH_WEIGHT, 16'd511));
        script.push_back(level_row(0, 16'd40000, 1));
        script.push_back(reg_row(CFG_SMOOTH_WEIGHT, 16'd0));
        script.push_back(level_row(0, 16'd1234, 1));
        script.push_back(reg_row(REG_SPARE, 16'hFFFF));
        script.push_back(level_row(0, 16'd4321, 1));
        script.push_back(reg_row(CFG_BAND_COUNT, 16'd0));
        script.push_back(known_row(0, 16'd100, 16'd0, 16'd0, 1'b0, 1'b1));
        script.push_back(reg_row(CFG_BAND_COUNT, 16'd255));
        script.push_back(known_row(127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        // rewriting the count drops every band back to its first beat
        script.push_back(reg_row(CFG_BAND_COUNT, 16'd128));
        script.push_back(known_row(127, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
        script.push_back(reg_row(CFG_BAND_COUNT, 16'd1));
        script.push_back(known_row(1, 16'd7, 16'd0, 16'd0, 1'b0, 1'b1));
        script.push_back(known_row(0, 16'd7, 16'd7, 16'd7, 1'b1, 1'b0));

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].reg_idx, script[i].value);
            else
                repeat (script[i].reps)
                    push_level(script[i].band, script[i].value,
                               script[i].known, script[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_reg(CFG_SMOOTH_WEIGHT, 16'd0);
                1: write_reg(CFG_SMOOTH_WEIGHT, 16'd256);
                2: write_reg(CFG_SMOOTH_WEIGHT, 16'd511);
                default: write_reg(CFG_SMOOTH_WEIGHT, CFG_DATA_W'($urandom_range(0, 300)));
            endcase
            case (p)
                0: write_reg(CFG_DECAY_STEP, 16'hFFFF);
                1: write_reg(CFG_DECAY_STEP, 16'd0);
                3: write_reg(CFG_DECAY_STEP, 16'd1);
                default: write_reg(CFG_DECAY_STEP, CFG_DATA_W'($urandom_range(0, 4000)));
            endcase
            case (p)
                0: write_reg(CFG_BAND_COUNT, 16'd128);
                1: write_reg(CFG_BAND_COUNT, 16'd1);
                2: write_reg(CFG_BAND_COUNT, 16'd255);
                3: write_reg(CFG_BAND_COUNT, 16'd3);
                5: write_reg(CFG_BAND_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
                default: write_reg(CFG_BAND_COUNT, CFG_DATA_W'($urandom_range(1, 128)));
            endcase
            if (p == PHASES - 1)
                calm = 1'b1;

            done = 0;
            while (done < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 6) begin
                    // peak, then a tail of lower levels that can outlast the hold
                    b = pick_band();
                    run = $urandom_range(8, 16);
                    push_level(b, LEVEL_BITS_DEF'($urandom_range(32768, 65535)));
                    repeat (run)
                        push_level(b, LEVEL_BITS_DEF'($urandom_range(0, 32767)));
                    done += run + 1;
                end else begin
                    b = ($urandom_range(0, 9) == 0) ? BAND_W'($urandom) : pick_band();
                    case ($urandom_range(0, 3))
                        0: lvl = $urandom_range(0, 1) ? '1 : '0;
                        1: lvl = LEVEL_BITS_DEF'($urandom);
                        2: lvl = LEVEL_BITS_DEF'($urandom_range(0, 255));
                        default: lvl = LEVEL_BITS_DEF'($urandom_range(49152, 65535));
                    endcase
                    push_level(b, lvl);
                    done++;
                end
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_meters.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d level beats over %0d register writes; checked %0d results",
                 beats_sent, reg_writes, results_checked);
        $display("Of those, %0d out-of-range bands and %0d with the peak held",
                 errors_seen, holds_seen);
        if (mismatches == 0 && expected_meters.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
